// ===== src/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority interrupt controller package
// Shared types, codes and reset values for the interrupt controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

  typedef enum logic [2:0] {
    FUNC_READ  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_ACK   = 3'd2,
    FUNC_RAISE = 3'd3,
    FUNC_LOWER = 3'd4
  } pic_func_e;

  localparam logic [1:0] STEP_BASE    = 2'd0;
  localparam logic [1:0] STEP_CASCADE = 2'd1;
  localparam logic [1:0] STEP_MODE    = 2'd2;

  localparam logic [1:0] SEL_CLEAR = 2'b10;
  localparam logic [1:0] SEL_SET   = 2'b11;

  localparam logic [7:0] EOI_NONSPECIFIC = 8'h20;
  localparam logic [4:0] EOI_SPECIFIC    = 5'b01100;
  localparam logic [7:0] BASE_MASK       = 8'hf8;
  localparam logic [7:0] MASK_RESET      = 8'hff;
  localparam logic [7:0] BASE_RESET      = 8'h08;
  localparam logic [2:0] SPURIOUS_LINE   = 3'd7;

  typedef struct packed {
    logic [7:0] request_bits;
    logic [7:0] service_bits;
    logic [7:0] mask_bits;
    logic [7:0] vector_base;
    logic [2:0] pending_line;
    logic       int_active;
    logic       read_service_select;
    logic       special_mask_on;
    logic       init_active;
    logic [1:0] init_step;
    logic       want_cascade_word;
    logic       want_mode_word;
  } pic_state_t;

  localparam pic_state_t STATE_RESET = '{
    request_bits:        8'h00,
    service_bits:        8'h00,
    mask_bits:           MASK_RESET,
    vector_base:         BASE_RESET,
    pending_line:        3'd0,
    int_active:          1'b0,
    read_service_select: 1'b0,
    special_mask_on:     1'b0,
    init_active:         1'b0,
    init_step:           STEP_BASE,
    want_cascade_word:   1'b0,
    want_mode_word:      1'b0
  };

  typedef struct packed {
    logic [2:0] func;
    logic       port_select;
    logic [7:0] write_data;
    logic [2:0] line_number;
  } pic_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] vector;
    logic       int_pin;
  } pic_result_t;

endpackage

`default_nettype wire

// ===== src/pic_step.sv =====
// ----------------------------------------------------------------------------
// Priority interrupt controller step logic
// Computes the next controller state and the result for one transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_step (
  input  wire pic_pkg::pic_state_t state_i,
  input  wire pic_pkg::pic_item_t  item_i,
  output pic_pkg::pic_state_t      state_o,
  output pic_pkg::pic_result_t     result_o
);

  function automatic pic_pkg::pic_state_t grant(input pic_pkg::pic_state_t s);
    pic_pkg::pic_state_t r;
    logic [7:0] ready;
    logic [7:0] below;
    logic [7:0] cand;
    r = s;
    ready = s.request_bits & ~s.mask_bits;
    if (s.special_mask_on) begin
      ready = ready & ~s.service_bits;
    end
    if (!s.special_mask_on && (s.service_bits != 8'h00)) begin
      below = (s.service_bits & (~s.service_bits + 8'd1)) - 8'd1;
    end else begin
      below = 8'hff;
    end
    cand = ready & below;
    if (!s.int_active && (cand != 8'h00)) begin
      for (int k = 7; k >= 0; k--) begin
        if (cand[k]) begin
          r.pending_line = 3'(k);
        end
      end
      r.request_bits = s.request_bits & ~(8'h01 << r.pending_line);
      r.int_active   = 1'b1;
    end
    return r;
  endfunction

  pic_pkg::pic_state_t ns;
  logic [7:0]          rd;
  logic [7:0]          vec;
  logic                do_grant;
  logic [7:0]          d;

  assign d = item_i.write_data;

  always_comb begin
    ns       = state_i;
    rd       = 8'h00;
    vec      = 8'h00;
    do_grant = 1'b0;
    unique case (pic_pkg::pic_func_e'(item_i.func))
      pic_pkg::FUNC_READ: begin
        if (item_i.port_select) begin
          rd = state_i.mask_bits;
        end else begin
          rd = state_i.read_service_select ? state_i.service_bits : state_i.request_bits;
        end
      end
      pic_pkg::FUNC_WRITE: begin
        if (item_i.port_select) begin
          if (state_i.init_active) begin
            unique case (state_i.init_step)
              pic_pkg::STEP_BASE: begin
                ns.vector_base = d & pic_pkg::BASE_MASK;
                if (state_i.want_cascade_word) begin
                  ns.init_step = pic_pkg::STEP_CASCADE;
                end else if (state_i.want_mode_word) begin
                  ns.init_step = pic_pkg::STEP_MODE;
                end else begin
                  ns.init_active = 1'b0;
                  ns.init_step   = pic_pkg::STEP_BASE;
                end
              end
              pic_pkg::STEP_CASCADE: begin
                if (state_i.want_mode_word) begin
                  ns.init_step = pic_pkg::STEP_MODE;
                end else begin
                  ns.init_active = 1'b0;
                  ns.init_step   = pic_pkg::STEP_BASE;
                end
              end
              default: begin
                ns.init_active = 1'b0;
                ns.init_step   = pic_pkg::STEP_BASE;
              end
            endcase
          end else begin
            ns.mask_bits = d;
            do_grant     = 1'b1;
          end
        end else if (d[4]) begin
          ns.init_active       = 1'b1;
          ns.init_step         = pic_pkg::STEP_BASE;
          ns.want_mode_word    = d[0];
          ns.want_cascade_word = ~d[1];
          ns.mask_bits         = pic_pkg::MASK_RESET;
          ns.service_bits      = 8'h00;
          ns.request_bits      = 8'h00;
          ns.int_active        = 1'b0;
        end else if (d[3]) begin
          if (d[1:0] == pic_pkg::SEL_CLEAR) begin
            ns.read_service_select = 1'b0;
          end else if (d[1:0] == pic_pkg::SEL_SET) begin
            ns.read_service_select = 1'b1;
          end
          if (d[6:5] == pic_pkg::SEL_CLEAR) begin
            ns.special_mask_on = 1'b0;
          end else if (d[6:5] == pic_pkg::SEL_SET) begin
            ns.special_mask_on = 1'b1;
            do_grant           = 1'b1;
          end
        end else if (d == pic_pkg::EOI_NONSPECIFIC) begin
          ns.service_bits = state_i.service_bits & (state_i.service_bits - 8'd1);
          do_grant        = 1'b1;
        end else if (d[7:3] == pic_pkg::EOI_SPECIFIC) begin
          ns.service_bits = state_i.service_bits & ~(8'h01 << d[2:0]);
          do_grant        = 1'b1;
        end
      end
      pic_pkg::FUNC_ACK: begin
        if (state_i.int_active) begin
          ns.int_active   = 1'b0;
          ns.service_bits = state_i.service_bits | (8'h01 << state_i.pending_line);
          ns.request_bits = state_i.request_bits & ~(8'h01 << state_i.pending_line);
          vec = {5'd0, state_i.pending_line} + state_i.vector_base;
        end else begin
          vec = {5'd0, pic_pkg::SPURIOUS_LINE} + state_i.vector_base;
        end
        do_grant = 1'b1;
      end
      pic_pkg::FUNC_RAISE: begin
        ns.request_bits = state_i.request_bits | (8'h01 << item_i.line_number);
        do_grant        = 1'b1;
      end
      pic_pkg::FUNC_LOWER: begin
        ns.request_bits = state_i.request_bits & ~(8'h01 << item_i.line_number);
        do_grant        = 1'b1;
      end
      default: begin
        ns = state_i;
      end
    endcase
    if (do_grant) begin
      ns = grant(ns);
    end
  end

  assign state_o            = ns;
  assign result_o.read_data = rd;
  assign result_o.vector    = vec;
  assign result_o.int_pin   = ns.int_active;

endmodule

`default_nettype wire

// ===== src/priority_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// Priority interrupt controller
// Eight-line fixed-priority interrupt controller with a transfer interface.
// ----------------------------------------------------------------------------
// Each transfer carries a register read, a register write, an acknowledge or
// a line raise or lower event, and returns exactly one result. A transfer is
// captured in an input register and processed once the output register can
// take a result; the controller state is then updated and the result is loaded
// into the output register. One transfer per cycle is sustained while the
// output does not stall; the figure is set by the single state update per
// cycle. A stalled output holds the result, and the input stalls only while
// both the input and output registers are full.
`default_nettype none

module priority_interrupt_controller (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] func_i,
  input  wire logic       port_select_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [2:0] line_number_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o,
  output logic [7:0]      vector_o,
  output logic            int_pin_o
);

  pic_pkg::pic_state_t  state_q;
  pic_pkg::pic_state_t  state_d;
  pic_pkg::pic_item_t   item_q;
  pic_pkg::pic_result_t result_q;
  pic_pkg::pic_result_t result_d;
  logic                 item_valid_q;
  logic                 out_valid_q;
  logic                 advance;
  logic                 take_in;

  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  pic_step u_step (
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      state_q      <= pic_pkg::STATE_RESET;
    end else begin
      if (take_in) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q.func        <= func_i;
      item_q.port_select <= port_select_i;
      item_q.write_data  <= write_data_i;
      item_q.line_number <= line_number_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = result_q.read_data;
  assign vector_o    = result_q.vector;
  assign int_pin_o   = result_q.int_pin;

`ifndef SYNTHESIS
  a_pin_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.int_pin == state_q.int_active))
    else $error("Interrupt pin differs from controller state.");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.init_active |-> (state_q.init_step == pic_pkg::STEP_BASE))
    else $error("Init step is nonzero outside the init sequence.");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid_q && out_valid_q && out_stall_i))
    else $error("Input stalled while a register is free.");
`endif

endmodule

`default_nettype wire
